@@ rtl/core/svfbb_pkg.sv @@
// Shared types, constants and the microcode program of the bell band filter.
package svfbb_pkg;

  localparam int CHANNELS = 8;
  localparam int ChIdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ChanW    = 3;
  localparam int SampleW  = 24;
  localparam int CoefW    = 31;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 8;
  localparam int StW      = 36;
  localparam int CW       = 32;
  localparam int FracW    = 28;
  localparam int AccW     = StW + 2;
  localparam int PcW      = 4;

  localparam logic [CfgIdxW-1:0] REG_WARP_GAIN       = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_DAMPING         = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_BELL_AMPLITUDE  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_LOOP_NORMALIZER = CfgIdxW'(3);

  localparam logic [CoefW-1:0] COEF_ONE = CoefW'(1) << FracW;

  localparam logic [PcW-1:0] STEP_IDLE = PcW'(0);
  localparam logic [PcW-1:0] STEP_PASS = PcW'(14);

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_LOAD, OP_DIFF, OP_COEF, OP_SUM1, OP_V1,
    OP_S1, OP_V2, OP_S2, OP_OUT, OP_PASS
  } op_e;

  typedef enum logic [1:0] {MUL_NONE, MUL_LO, MUL_HI} mul_e;
  typedef enum logic [1:0] {A_K, A_T, A_V1} asel_e;
  typedef enum logic [1:0] {C_AM1, C_G, C_H, C_C} csel_e;
  typedef enum logic [1:0] {JC_NEXT, JC_WAIT_IN, JC_PASS, JC_WAIT_OUT} jc_e;

  typedef struct packed {
    op_e            op;
    mul_e           mul;
    asel_e          sela;
    csel_e          selc;
    jc_e            jc;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic pass;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [CoefW-1:0] g;
    logic [CoefW-1:0] k;
    logic [CoefW-1:0] a;
    logic [CoefW-1:0] h;
  } coef_t;

  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = '{OP_LATCH, MUL_NONE, A_T,  C_G,   JC_WAIT_IN,  STEP_IDLE};
      4'd1:    w = '{OP_LOAD,  MUL_LO,   A_K,  C_AM1, JC_PASS,     STEP_PASS};
      4'd2:    w = '{OP_DIFF,  MUL_HI,   A_K,  C_AM1, JC_NEXT,     STEP_IDLE};
      4'd3:    w = '{OP_COEF,  MUL_LO,   A_T,  C_G,   JC_NEXT,     STEP_IDLE};
      4'd4:    w = '{OP_NONE,  MUL_HI,   A_T,  C_G,   JC_NEXT,     STEP_IDLE};
      4'd5:    w = '{OP_SUM1,  MUL_NONE, A_T,  C_G,   JC_NEXT,     STEP_IDLE};
      4'd6:    w = '{OP_NONE,  MUL_LO,   A_T,  C_H,   JC_NEXT,     STEP_IDLE};
      4'd7:    w = '{OP_NONE,  MUL_HI,   A_T,  C_H,   JC_NEXT,     STEP_IDLE};
      4'd8:    w = '{OP_V1,    MUL_NONE, A_V1, C_G,   JC_NEXT,     STEP_IDLE};
      4'd9:    w = '{OP_NONE,  MUL_LO,   A_V1, C_G,   JC_NEXT,     STEP_IDLE};
      4'd10:   w = '{OP_S1,    MUL_HI,   A_V1, C_G,   JC_NEXT,     STEP_IDLE};
      4'd11:   w = '{OP_V2,    MUL_LO,   A_V1, C_C,   JC_NEXT,     STEP_IDLE};
      4'd12:   w = '{OP_S2,    MUL_HI,   A_V1, C_C,   JC_NEXT,     STEP_IDLE};
      4'd13:   w = '{OP_OUT,   MUL_NONE, A_T,  C_G,   JC_WAIT_OUT, STEP_IDLE};
      4'd14:   w = '{OP_PASS,  MUL_NONE, A_T,  C_G,   JC_WAIT_OUT, STEP_IDLE};
      default: w = '{OP_NONE,  MUL_NONE, A_T,  C_G,   JC_WAIT_OUT, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/svfbb_if.sv @@
// Channel interfaces: sample input, filtered output and register writes.
interface svfbb_in_if;
  logic                                valid;
  logic                                ready;
  logic [svfbb_pkg::ChanW-1:0]         channel;
  logic signed [svfbb_pkg::SampleW-1:0] sample_in;
  modport source (output valid, channel, sample_in, input ready);
  modport sink (input valid, channel, sample_in, output ready);
endinterface

interface svfbb_out_if;
  logic                                valid;
  logic                                ready;
  logic [svfbb_pkg::ChanW-1:0]         channel_out;
  logic signed [svfbb_pkg::SampleW-1:0] sample_out;
  modport source (output valid, channel_out, sample_out, input ready);
  modport sink (input valid, channel_out, sample_out, output ready);
endinterface

interface svfbb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [svfbb_pkg::CfgIdxW-1:0]  index;
  logic [svfbb_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/svf_bell_band_filter_unit.sv @@
// Bell band filter top level: coefficient registers, sequencer and datapath.
// A channel outside the state range passes straight through.
// One item is processed at a time on the shared 36x16 multiplier, which runs five
// two-pass products per item. The output register frees the next input early.
// Reset: integrators cleared in place, coefficients set to pass-through; no sweep.
module svf_bell_band_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  svfbb_in_if.sink    in_i,
  svfbb_out_if.source out_o,
  svfbb_cfg_if.sink   cfg_i
);
  import svfbb_pkg::*;

  coef_t coef_q;
  ctrl_t ctrl;
  stat_t stat;
  logic  en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.g <= '0;
      coef_q.k <= '0;
      coef_q.a <= COEF_ONE;
      coef_q.h <= COEF_ONE;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WARP_GAIN:       coef_q.g <= cfg_i.data[CoefW-1:0];
        REG_DAMPING:         coef_q.k <= cfg_i.data[CoefW-1:0];
        REG_BELL_AMPLITUDE:  coef_q.a <= cfg_i.data[CoefW-1:0];
        REG_LOOP_NORMALIZER: coef_q.h <= cfg_i.data[CoefW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  svfbb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .en_o       (en),
    .in_ready_o (in_i.ready)
  );

  svfbb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .en_i          (en),
    .coef_i        (coef_q),
    .in_channel_i  (in_i.channel),
    .in_sample_i   (in_i.sample_in),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_channel_o (out_o.channel_out),
    .out_sample_o  (out_o.sample_out),
    .stat_o        (stat)
  );

endmodule

@@ rtl/core/svfbb_mul.sv @@
// Shared Q12.24 by Q4.28 multiplier: two 36x16 passes, rounding and saturation.
module svfbb_mul (
  input  logic                            clk_i,
  input  svfbb_pkg::mul_e                 op_i,
  input  logic signed [svfbb_pkg::StW-1:0] a_i,
  input  logic signed [svfbb_pkg::CW-1:0]  c_i,
  output logic signed [svfbb_pkg::StW-1:0] prod_o
);
  import svfbb_pkg::*;

  localparam int HalfW = CW / 2;
  localparam int ProdW = StW + CW;
  localparam int RW    = ProdW - FracW;
  localparam logic [ProdW-1:0] RND = ProdW'(1) << (FracW - 1);

  logic [StW-1:0]       ma;
  logic [CW-1:0]        mc;
  logic [StW+HalfW-1:0] pp_lo;
  logic [StW+HalfW-1:0] pp_hi;
  logic [ProdW-1:0]     p_d, p_q;
  logic                 neg_d, neg_q;
  logic [RW-1:0]        r;
  logic                 pos_ovf, neg_ovf;

  always_comb begin
    ma    = a_i[StW-1] ? (~a_i + 1'b1) : a_i;
    mc    = c_i[CW-1] ? (~c_i + 1'b1) : c_i;
    pp_lo = ma * mc[HalfW-1:0];
    pp_hi = ma * mc[CW-1:HalfW];
    p_d   = p_q;
    neg_d = neg_q;
    case (op_i)
      MUL_LO: p_d = ProdW'(pp_lo);
      MUL_HI: begin
        p_d   = p_q + {pp_hi, {HalfW{1'b0}}} + RND;
        neg_d = a_i[StW-1] ^ c_i[CW-1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    neg_q <= neg_d;
  end

  always_comb begin
    r       = p_q[ProdW-1:FracW];
    pos_ovf = |r[RW-1:StW-1];
    neg_ovf = (|r[RW-1:StW]) || (r[StW-1] && (|r[StW-2:0]));
    if (neg_q) begin
      prod_o = neg_ovf ? {1'b1, {(StW-1){1'b0}}} : -StW'(r);
    end else begin
      prod_o = pos_ovf ? {1'b0, {(StW-1){1'b1}}} : StW'(r);
    end
  end

endmodule

@@ rtl/core/svfbb_dp.sv @@
// Datapath: integrator state, working registers, saturating adder, output register.
module svfbb_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svfbb_pkg::ctrl_t                    ctrl_i,
  input  logic                                en_i,
  input  svfbb_pkg::coef_t                    coef_i,
  input  logic [svfbb_pkg::ChanW-1:0]         in_channel_i,
  input  logic signed [svfbb_pkg::SampleW-1:0] in_sample_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [svfbb_pkg::ChanW-1:0]         out_channel_o,
  output logic signed [svfbb_pkg::SampleW-1:0] out_sample_o,
  output svfbb_pkg::stat_t                    stat_o
);
  import svfbb_pkg::*;

  logic [ChanW-1:0]          ch_q;
  logic [ChIdxW-1:0]         ch_idx;
  logic signed [SampleW-1:0] x_q;
  logic signed [SampleW:0]   x24;
  logic signed [StW-1:0]     s1_q, s2_q, t_q, v1_q, v2_q;
  logic signed [CW-1:0]      c_q;
  logic signed [StW-1:0]     st1_q [CHANNELS];
  logic signed [StW-1:0]     st2_q [CHANNELS];
  logic                      out_valid_q;
  logic [ChanW-1:0]          och_q;
  logic signed [SampleW-1:0] osmp_q;

  mul_e                      mul_op;
  logic signed [StW-1:0]     mul_a;
  logic signed [CW-1:0]      mul_c;
  logic signed [StW-1:0]     prod;
  logic signed [CW-1:0]      prod32;

  logic signed [AccW-1:0]    add_a, add_b, add_s;
  logic signed [StW-1:0]     add_sat;
  logic signed [AccW-1:0]    y, yr;
  logic signed [SampleW-1:0] yq;

  assign ch_idx = ChIdxW'(ch_q);
  assign x24    = {x_q, 1'b0};
  assign mul_op = en_i ? ctrl_i.mul : MUL_NONE;

  always_comb begin
    case (ctrl_i.sela)
      A_K:     mul_a = {{(StW-CoefW){1'b0}}, coef_i.k};
      A_V1:    mul_a = v1_q;
      default: mul_a = t_q;
    endcase
    case (ctrl_i.selc)
      C_AM1:   mul_c = {1'b0, coef_i.a} - {1'b0, COEF_ONE};
      C_H:     mul_c = {1'b0, coef_i.h};
      C_C:     mul_c = c_q;
      default: mul_c = {1'b0, coef_i.g};
    endcase
  end

  svfbb_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .a_i    (mul_a),
    .c_i    (mul_c),
    .prod_o (prod)
  );

  always_comb begin
    case (ctrl_i.op)
      OP_DIFF: begin
        add_a = AccW'(x24);
        add_b = -AccW'(s2_q);
      end
      OP_SUM1: begin
        add_a = AccW'(s1_q);
        add_b = AccW'(prod);
      end
      OP_V2: begin
        add_a = AccW'(s2_q);
        add_b = AccW'(prod);
      end
      OP_S1: begin
        add_a = AccW'(v1_q) <<< 1;
        add_b = -AccW'(s1_q);
      end
      OP_S2: begin
        add_a = AccW'(v2_q) <<< 1;
        add_b = -AccW'(s2_q);
      end
      default: begin
        add_a = AccW'(x24);
        add_b = AccW'(prod);
      end
    endcase
    add_s = add_a + add_b;
    if ((&add_s[AccW-1:StW-1]) || !(|add_s[AccW-1:StW-1])) begin
      add_sat = StW'(add_s);
    end else begin
      add_sat = add_s[AccW-1] ? {1'b1, {(StW-1){1'b0}}} : {1'b0, {(StW-1){1'b1}}};
    end
  end

  // output: x + e, rounded half up to Q1.23 and saturated
  always_comb begin
    y  = AccW'(x24) + AccW'(prod);
    yr = (y + AccW'(1)) >>> 1;
    if ((&yr[AccW-1:SampleW-1]) || !(|yr[AccW-1:SampleW-1])) begin
      yq = SampleW'(yr);
    end else begin
      yq = yr[AccW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end
    if ((&prod[StW-1:CW-1]) || !(|prod[StW-1:CW-1])) begin
      prod32 = CW'(prod);
    end else begin
      prod32 = prod[StW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      st1_q       <= '{default: '0};
      st2_q       <= '{default: '0};
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (en_i && (ctrl_i.op == OP_OUT || ctrl_i.op == OP_PASS)) begin
        out_valid_q <= 1'b1;
      end
      if (en_i && ctrl_i.op == OP_OUT) begin
        st1_q[ch_idx] <= s1_q;
        st2_q[ch_idx] <= s2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (ctrl_i.op)
        OP_LATCH: begin
          ch_q <= in_channel_i;
          x_q  <= in_sample_i;
        end
        OP_LOAD: begin
          s1_q <= st1_q[ch_idx];
          s2_q <= st2_q[ch_idx];
        end
        OP_DIFF, OP_SUM1: t_q <= add_sat;
        OP_COEF:          c_q <= prod32;
        OP_V1:            v1_q <= prod;
        OP_S1:            s1_q <= add_sat;
        OP_V2:            v2_q <= add_sat;
        OP_S2:            s2_q <= add_sat;
        OP_OUT: begin
          och_q  <= ch_q;
          osmp_q <= yq;
        end
        OP_PASS: begin
          och_q  <= ch_q;
          osmp_q <= x_q;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = och_q;
  assign out_sample_o    = osmp_q;
  assign stat_o.pass     = (int'(ch_q) >= CHANNELS);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

endmodule

@@ rtl/core/svfbb_seq.sv @@
// Microcode sequencer: step counter, program table lookup and jump logic.
module svfbb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  svfbb_pkg::stat_t    stat_i,
  output svfbb_pkg::ctrl_t    ctrl_o,
  output logic                en_o,
  output logic                in_ready_o
);
  import svfbb_pkg::*;

  logic [PcW-1:0] pc_d, pc_q;
  ctrl_t          cw;
  logic           stall;

  always_comb begin
    cw    = ucode(pc_q);
    stall = (cw.jc == JC_WAIT_IN && !in_valid_i) ||
            (cw.jc == JC_WAIT_OUT && stat_i.out_busy);
    pc_d  = pc_q;
    if (!stall) begin
      case (cw.jc)
        JC_PASS:     pc_d = stat_i.pass ? cw.target : pc_q + 1'b1;
        JC_WAIT_OUT: pc_d = cw.target;
        default:     pc_d = pc_q + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o     = cw;
  assign en_o       = !stall;
  assign in_ready_o = (cw.op == OP_LATCH);

endmodule
